### src/stlbs_pkg.sv
// ----------------------------------------------------------------------------
// stlbs_pkg: shared types and constants
// Field widths, command codes, register map and the control/status bundles
// passed between the search controller and datapath.
// ----------------------------------------------------------------------------
package stlbs_pkg;

	localparam int CNT_W     = 11;  // entry_count / position width
	localparam int ADDR_IN_W = 10;  // entry_address width
	localparam int DATA_W    = 32;  // table entry / target width
	localparam int PADDR_W   = 3;   // APB byte address width
	localparam int PDATA_W   = 32;  // APB data width

	// command field codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// register index, taken from the word address bit of paddr
	localparam logic REG_ENTRY_COUNT = 1'b0;

	// controller -> datapath
	typedef struct packed {
		logic wr_en;   // write one table entry
		logic load;    // take a search target, issue first table read
		logic step;    // one halving step, issue next read
		logic finish;  // final compare, present position
	} stlbs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;  // remaining count is zero (empty table)
		logic last;      // remaining count is one: pending read is the final compare
	} stlbs_sts_t;

endpackage

### src/stlbs_dpath.sv
// ----------------------------------------------------------------------------
// stlbs_dpath: search datapath
// Table memory, base/count registers, signed compare and result register.
// One table read per cycle; next read address picked by the compare result.
// ----------------------------------------------------------------------------
module stlbs_dpath import stlbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stlbs_cmd_t                  cmd,
	output stlbs_sts_t                  sts,
	input  logic [CNT_W-1:0]            entry_count,
	input  logic [ADDR_IN_W-1:0]        entry_address,
	input  logic signed [DATA_W-1:0]    item_value,
	output logic                        done,
	output logic [CNT_W-1:0]            position
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [DATA_W-1:0]        mem [TABLE_DEPTH];
	logic [DATA_W-1:0]        rdata_q;
	logic signed [DATA_W-1:0] target_q;
	logic [CNT_W-1:0]         base_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         position_q;
	logic                     done_q;

	logic [CNT_W-1:0] sat_count;
	logic [CNT_W-1:0] half;
	logic [CNT_W-1:0] next_count;
	logic [CNT_W-1:0] next_half;
	logic [CNT_W-1:0] base_up;
	logic [CNT_W-1:0] addr_lo;
	logic [CNT_W-1:0] addr_hi;
	logic [CNT_W-1:0] rd_addr;
	logic             less;
	logic             wr_ok;

	// counts above the table depth search the whole table
	assign sat_count = (32'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : entry_count;

	assign half       = count_q >> 1;
	assign next_count = count_q - half;
	assign next_half  = next_count >> 1;  // zero once next_count is one: final read at base
	assign base_up    = base_q + half;
	assign addr_lo    = base_q + next_half;
	assign addr_hi    = base_up + next_half;

	assign less    = $signed(rdata_q) < target_q;
	assign rd_addr = cmd.load ? (sat_count >> 1) : (less ? addr_hi : addr_lo);
	assign wr_ok   = cmd.wr_en && (32'(entry_address) < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[AW'(entry_address)] <= DATA_W'(item_value);
		end
		if (cmd.load || cmd.step) begin
			rdata_q <= mem[AW'(rd_addr)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= item_value;
			base_q   <= '0;
			count_q  <= sat_count;
		end else if (cmd.step) begin
			base_q  <= less ? base_up : base_q;
			count_q <= next_count;
		end
		if (cmd.finish) begin
			position_q <= base_q + CNT_W'(less && !sts.cnt_zero);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign sts.cnt_zero = (count_q == '0);
	assign sts.last     = (count_q == CNT_W'(1));
	assign done         = done_q;
	assign position     = position_q;

endmodule

### src/stlbs_ctrl.sv
// ----------------------------------------------------------------------------
// stlbs_ctrl: search controller
// Two-state sequencer: accepts commands when idle, then steps the datapath
// one halving per cycle until the final compare.
// ----------------------------------------------------------------------------
module stlbs_ctrl import stlbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        command,
	input  stlbs_sts_t  sts,
	output stlbs_cmd_t  cmd,
	output logic        busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_SEARCH) begin
						cmd.load = 1'b1;
						state_d  = ST_RUN;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			ST_RUN: begin
				if (sts.cnt_zero || sts.last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_RUN);

endmodule

### src/sorted_table_lower_bound_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search_unit: lower-bound search over a RAM table
// Holds a table of signed 32-bit entries and answers lower-bound queries
// with a branch-free binary search, one table read per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer happens on a rising edge with start high and
//   busy low. command = write stores item_value at entry_address (addresses
//   at or above TABLE_DEPTH are dropped); busy stays low and no result
//   follows. command = search looks up item_value.
//   Result channel: done is high for exactly one cycle with position valid;
//   the receiver cannot stall it, so there is no backpressure path.
//   Config: APB register 0 (byte address 0) is entry_count, the number of
//   table entries searched; values above TABLE_DEPTH are clamped. Write it
//   only while no search is in flight.
//   Timing: a search with n = min(entry_count, TABLE_DEPTH) runs the accept
//   cycle with the first table read, then ceil(log2 n) halving steps (none
//   for n <= 1), then the final compare; busy drops on the edge that raises
//   done, so the next command can transfer in the done cycle. Reads are
//   serialized by the table's single registered read port: each step's
//   address depends on the previous read.
//   Reset: arst_n clears the controller, done and entry_count. The table
//   is not cleared; a search must touch only entries written since reset.
// ----------------------------------------------------------------------------
module sorted_table_lower_bound_search_unit import stlbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command channel
	input  logic                     start,
	output logic                     busy,
	input  logic                     command,
	input  logic [ADDR_IN_W-1:0]     entry_address,
	input  logic signed [DATA_W-1:0] item_value,
	// result channel
	output logic                     done,
	output logic [CNT_W-1:0]         position,
	// APB config port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready
);

	stlbs_cmd_t       cmd;
	stlbs_sts_t       sts;
	logic [CNT_W-1:0] entry_count_q;
	logic             cfg_wr;
	logic             reg_sel;

	// ---------------- config register ----------------
	// Zero-wait APB; word address bit picks the register, low bits ignored.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_ENTRY_COUNT);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr) begin
			entry_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? PDATA_W'(entry_count_q) : '0;

	// ---------------- controller ----------------
	// IDLE takes commands; RUN issues one halving step per cycle until the
	// remaining count is one or zero, then finishes with the final compare.
	stlbs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	// ---------------- datapath ----------------
	// Table RAM with registered read, base/count registers and the
	// signed compare that selects the next read address.
	stlbs_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.entry_count   (entry_count_q),
		.entry_address (entry_address),
		.item_value    (item_value),
		.done          (done),
		.position      (position)
	);

	// ---------------- assertions ----------------
	// a result strobe only follows a cycle of search work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a search in progress");

	// lower bound never exceeds the configured entry count
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (position <= entry_count_q))
		else $error("position beyond entry count");

	// a write transfer never starts a search
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_WRITE)) |=> !busy)
		else $error("write command made the unit busy");

	// a search transfer always makes the unit busy after the accepting edge
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_SEARCH)) |=> busy)
		else $error("search command not taken up");

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_table_lower_bound_search_unit
// Loads the search table through write commands, sets entry_count over APB
// and checks every search result against a lower-bound predictor kept in
// step with each accepted transfer.
// ----------------------------------------------------------------------------
module testbench;
	import stlbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH   = 1024;
	localparam int SETTLE_CYCLES = 16;      // covers the worst-case search
	localparam int CYCLE_LIMIT   = 500000;  // slowest legal run is far below this

	localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VALUE_MAX = ~VALUE_MIN;

	// entry_count sits at byte address 4 * register index
	localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = PADDR_W'(4 * int'(REG_ENTRY_COUNT));

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     command;
	logic [ADDR_IN_W-1:0]     entry_address;
	logic signed [DATA_W-1:0] item_value;
	logic                     done;
	logic [CNT_W-1:0]         position;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [PADDR_W-1:0]       paddr;
	logic [PDATA_W-1:0]       pwdata;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;

	// Shadow of the block: table contents and entry_count as the DUT should hold them.
	logic signed [DATA_W-1:0] table_shadow [TABLE_DEPTH];
	logic [CNT_W-1:0]         shadow_entry_count;

	// Entries written since reset; a search only ever walks written entries.
	logic                     written [TABLE_DEPTH];

	// Positions predicted for accepted searches, oldest first.
	logic [CNT_W-1:0]         pending_positions [$];

	int unsigned send_idle_pct;    // chance per cycle that the sender holds start low
	int unsigned mismatch_count;
	int unsigned searches_sent;
	int unsigned writes_sent;
	int unsigned config_writes;
	int unsigned results_checked;
	int unsigned cycle_count;

	sorted_table_lower_bound_search_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.entry_address(entry_address),
		.item_value   (item_value),
		.done         (done),
		.position     (position),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				pending_positions.size());
			$display("sorted_table_lower_bound_search_unit verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		$display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
		mismatch_count++;
	endtask

	// Branch-free lower bound over the shadow table, same halving order as the
	// hardware so unsorted tables give the same answer too. Count saturates at
	// the table depth.
	function automatic logic [CNT_W-1:0] lower_bound_of(input logic signed [DATA_W-1:0] target);
		int unsigned span;
		int unsigned base;
		int unsigned half;
		span = (shadow_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_entry_count;
		base = 0;
		if (span == 0)
			return '0;
		while (span > 1) begin
			half = span >> 1;
			if (table_shadow[base + half] < target)
				base += half;
			span -= half;
		end
		return CNT_W'(base + ((table_shadow[base] < target) ? 1 : 0));
	endfunction

	// Default content for an entry first touched by a search: ascending over
	// the full signed range, so a table built this way stays sorted.
	function automatic logic signed [DATA_W-1:0] spread_value(input int unsigned idx);
		longint step_size;
		step_size = (longint'(1) << DATA_W) / TABLE_DEPTH;
		return VALUE_MIN + DATA_W'(longint'(idx) * step_size);
	endfunction

	// Result checker. done/position are read at the rising edge that ends the
	// strobe cycle; there is no backpressure so every strobe is a transfer.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_positions.size() == 0) begin
				report_mismatch("position with no search outstanding", 0, position);
			end else begin
				if (position !== pending_positions[0])
					report_mismatch("position", pending_positions[0], position);
				void'(pending_positions.pop_front());
				results_checked++;
			end
		end
	end

	// One command transfer. Idle cycles are drawn per cycle before start goes
	// high; start then stays up until a rising edge sees busy low. busy is
	// checked at the falling edge, where it is stable until the next rising edge.
	// Returns right after the accepting edge, so back-to-back calls that draw no
	// idle cycles keep start high without ever dropping it.
	task automatic send_item(input logic cmd, input logic [ADDR_IN_W-1:0] addr,
		input logic signed [DATA_W-1:0] value);
		logic accepted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			start         = 1'b0;
			command       = 1'($urandom());       // junk while idle: must be ignored
			entry_address = ADDR_IN_W'($urandom());
			item_value    = $urandom();
			@(posedge clk);
		end
		@(negedge clk);
		command       = cmd;
		entry_address = addr;
		item_value    = value;
		start         = 1'b1;
		accepted      = 1'b0;
		while (!accepted) begin
			if (busy) begin
				@(posedge clk);
				@(negedge clk);
			end else begin
				@(posedge clk);
				accepted = 1'b1;
			end
		end
		// transfer taken at this edge: update the shadow or queue the prediction
		if (cmd == CMD_WRITE) begin
			table_shadow[addr] = value;
			written[addr]      = 1'b1;
			writes_sent++;
		end else begin
			pending_positions = {pending_positions, lower_bound_of(value)};
			searches_sent++;
		end
	endtask

	task automatic write_entry(input int unsigned addr, input logic signed [DATA_W-1:0] value);
		send_item(CMD_WRITE, ADDR_IN_W'(addr), value);
	endtask

	// Walk the halving path of the coming search and write every entry on it
	// that has not been written yet, so the search reads written entries only.
	task automatic cover_search_path(input logic signed [DATA_W-1:0] target);
		int unsigned span;
		int unsigned base;
		int unsigned half;
		span = (shadow_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_entry_count;
		base = 0;
		if (span == 0)
			return;
		while (span > 1) begin
			half = span >> 1;
			if (!written[base + half])
				write_entry(base + half, spread_value(base + half));
			if (table_shadow[base + half] < target)
				base += half;
			span -= half;
		end
		if (!written[base])
			write_entry(base, spread_value(base));
	endtask

	// entry_address is a don't-care for searches; randomize it anyway
	task automatic search(input logic signed [DATA_W-1:0] target);
		cover_search_path(target);
		send_item(CMD_SEARCH, ADDR_IN_W'($urandom_range(0, TABLE_DEPTH - 1)), target);
	endtask

	// Drop start, let every search drain, then wait out a full search time in
	// case the block is still finishing one.
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB setup + access phase; write lands on the edge with pready high.
	task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
		output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = ENTRY_COUNT_ADDR;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		@(posedge clk);
	endtask

	// Write entry_count while idle (random junk above the 11 register bits),
	// then read it back.
	task automatic set_entry_count(input logic [CNT_W-1:0] count_value);
		logic [PDATA_W-1:0] wdata;
		logic [PDATA_W-1:0] readback;
		wait_idle();
		wdata = $urandom();
		wdata[CNT_W-1:0] = count_value;
		apb_access(1'b1, wdata, readback);
		shadow_entry_count = count_value;
		config_writes++;
		apb_access(1'b0, '0, readback);
		if (readback[CNT_W-1:0] !== count_value)
			report_mismatch("entry_count readback", count_value, readback[CNT_W-1:0]);
	endtask

	// Ascending fill of entries 0..n-1; a quarter of the steps repeat the
	// previous value so duplicates show up. Clamps at the top of the range.
	task automatic fill_sorted(input int unsigned n, input longint first,
		input int unsigned stride);
		longint v;
		v = first;
		for (int unsigned i = 0; i < n; i++) begin
			write_entry(i, v[DATA_W-1:0]);
			if ($urandom_range(0, 3) != 0)
				v += $urandom_range(1, stride);
			if (v > longint'(VALUE_MAX))
				v = longint'(VALUE_MAX);
		end
	endtask

	// Targets aimed around table contents: exact hits, one off either side,
	// range extremes and plain random values.
	function automatic logic signed [DATA_W-1:0] random_target(input int unsigned span);
		int unsigned idx;
		logic signed [DATA_W-1:0] pick;
		idx  = (span == 0) ? 0 : $urandom_range(0, span - 1);
		pick = written[idx] ? table_shadow[idx] : spread_value(idx);
		case ($urandom_range(0, 5))
			0, 1: return $urandom();
			2: return pick;
			3: return pick - 1;
			4: return pick + 1;
			default: return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
		endcase
	endfunction

	// Reset value of entry_count, and searches on an empty table.
	task automatic test_empty_table();
		logic [PDATA_W-1:0] readback;
		apb_access(1'b0, '0, readback);
		if (readback[CNT_W-1:0] !== '0)
			report_mismatch("entry_count after reset", 0, readback[CNT_W-1:0]);
		search(VALUE_MIN);
		search('0);
		search(VALUE_MAX);
	endtask

	// Small hand-built table: range ends, duplicates, odd counts, count 1,
	// an unsorted entry and a return to count 0.
	task automatic test_directed_table();
		set_entry_count(CNT_W'(5));
		write_entry(0, VALUE_MIN);
		write_entry(1, -5);
		write_entry(2, -5);
		write_entry(3, 7);
		write_entry(4, VALUE_MAX);
		search(VALUE_MIN);
		search(VALUE_MIN + 1);
		search(-5);
		search(-4);
		search(7);
		search(8);
		search(VALUE_MAX);
		set_entry_count(CNT_W'(1));
		search(VALUE_MIN);
		search(VALUE_MAX);
		set_entry_count(CNT_W'(2));
		search(-5);
		search(0);
		set_entry_count(CNT_W'(3));
		search(-5);
		// break the ordering: no error flag, just whatever the halving gives
		set_entry_count(CNT_W'(5));
		write_entry(1, 100);
		search(7);
		search(101);
		set_entry_count(CNT_W'(0));
		search(7);
	endtask

	// Full-depth searches over a sorted table that is built along each search
	// path, then counts just below the depth and counts that must saturate.
	task automatic test_full_table();
		for (int unsigned i = 0; i < 5; i++)
			write_entry(i, spread_value(i));
		set_entry_count(CNT_W'(TABLE_DEPTH));
		search(VALUE_MIN);
		search(VALUE_MAX);
		repeat (16) search(random_target(TABLE_DEPTH));
		set_entry_count(CNT_W'(TABLE_DEPTH - 1));
		repeat (6) search(random_target(TABLE_DEPTH - 1));
		set_entry_count(CNT_W'(TABLE_DEPTH + 1));
		repeat (6) search(random_target(TABLE_DEPTH));
		set_entry_count('1);
		repeat (6) search(random_target(TABLE_DEPTH));
	endtask

	// Random phases: new entry_count each phase (mostly small), small tables
	// rebuilt sorted with random content or scrambled, then searches mixed
	// with stray writes anywhere in the table.
	task automatic test_random_traffic(input int unsigned idle_pct);
		logic [CNT_W-1:0] count_value;
		int unsigned span;
		int s;
		send_idle_pct = idle_pct;
		repeat (2) begin
			case ($urandom_range(0, 9))
				0: count_value = CNT_W'($urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 1));
				1: count_value = CNT_W'($urandom_range(100, TABLE_DEPTH));
				default: count_value = CNT_W'($urandom_range(0, 48));
			endcase
			set_entry_count(count_value);
			span = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value;
			if (span <= 48) begin
				if ($urandom_range(0, 3) == 0) begin
					for (int unsigned i = 0; i < span; i++)
						write_entry(i, $urandom());
				end else begin
					s = $urandom();
					fill_sorted(span, longint'(s),
						$urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(1, 50000000));
				end
			end
			repeat (32) begin
				if ($urandom_range(0, 99) < 12)
					write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom());
				else
					search(random_target(span));
			end
		end
	endtask

	initial begin
		// every input known from time zero; reset asserted first
		arst_n             = 1'b0;
		start              = 1'b0;
		command            = CMD_WRITE;
		entry_address      = '0;
		item_value         = '0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		shadow_entry_count = '0;
		send_idle_pct      = 11;
		mismatch_count     = 0;
		searches_sent      = 0;
		writes_sent        = 0;
		config_writes      = 0;
		results_checked    = 0;
		cycle_count        = 0;
		foreach (table_shadow[i]) begin
			table_shadow[i] = '0;
			written[i]      = 1'b0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// sender idles often in the first part, heavily in the second, never in the last
		test_empty_table();
		test_directed_table();
		test_full_table();
		test_random_traffic(11);
		test_random_traffic(79);
		test_random_traffic(0);

		wait_idle();
		$display("run covered %0d searches and %0d table writes across %0d entry_count settings",
			searches_sent, writes_sent, config_writes);
		$display("%0d positions checked, %0d mismatches, %0d cycles",
			results_checked, mismatch_count, cycle_count);
		if (mismatch_count == 0)
			$display("sorted_table_lower_bound_search_unit verification clean");
		else
			$display("sorted_table_lower_bound_search_unit verification failed");
		$finish;
	end

endmodule

### filelist.f
src/stlbs_pkg.sv
src/stlbs_dpath.sv
src/stlbs_ctrl.sv
src/sorted_table_lower_bound_search_unit.sv
bench/testbench.sv
